// ----- sv/pvm_pkg.sv -----
// shared types and constants of the pcm voice mixer
package pvm_pkg;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_START = 3'd2;
    localparam logic [2:0] MODE_STOP  = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    localparam logic [15:0] UNITY_GAIN = 16'h8000;
    localparam logic [1:0]  PAN_LEFT   = 2'b01;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VOICE,
        S_SCALE,
        S_SAT,
        S_MUL_L,
        S_ADD_L,
        S_MUL_R,
        S_ADD_R,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_mem;
        logic set_voice;
        logic start_voice;
        logic stop_voice;
        logic tick_start;
        logic visit;
        logic next_voice;
        logic scale;
        logic sat;
        logic mul;
        logic add;
        logic ch;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic contrib;
        logic use_l;
        logic use_r;
        logic last;
        logic out_busy;
    } t_status;

endpackage

// ----- sv/pvm_ctrl.sv -----
// controller state machine of the pcm voice mixer
module pvm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_mode,
    input  pvm_pkg::t_status i_st,
    output pvm_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);

    pvm_pkg::t_state r_state;
    pvm_pkg::t_state n_state;
    logic            accept;

    assign o_in_stall = (r_state != pvm_pkg::S_IDLE);
    assign accept     = i_in_valid && (r_state == pvm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pvm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pvm_pkg::S_IDLE: begin
                if (accept && i_mode == pvm_pkg::MODE_TICK) begin
                    n_state = pvm_pkg::S_VOICE;
                end
            end
            pvm_pkg::S_VOICE: begin
                if (i_st.contrib) begin
                    n_state = pvm_pkg::S_SCALE;
                end else if (i_st.last) begin
                    n_state = pvm_pkg::S_DONE;
                end
            end
            pvm_pkg::S_SCALE: n_state = pvm_pkg::S_SAT;
            pvm_pkg::S_SAT:   n_state = i_st.use_l ? pvm_pkg::S_MUL_L : pvm_pkg::S_MUL_R;
            pvm_pkg::S_MUL_L: n_state = pvm_pkg::S_ADD_L;
            pvm_pkg::S_ADD_L: begin
                priority if (i_st.use_r) begin
                    n_state = pvm_pkg::S_MUL_R;
                end else if (i_st.last) begin
                    n_state = pvm_pkg::S_DONE;
                end else begin
                    n_state = pvm_pkg::S_VOICE;
                end
            end
            pvm_pkg::S_MUL_R: n_state = pvm_pkg::S_ADD_R;
            pvm_pkg::S_ADD_R: n_state = i_st.last ? pvm_pkg::S_DONE : pvm_pkg::S_VOICE;
            pvm_pkg::S_DONE: begin
                if (!i_st.out_busy) begin
                    n_state = pvm_pkg::S_IDLE;
                end
            end
            default: n_state = pvm_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            pvm_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.wr_mem      = (i_mode == pvm_pkg::MODE_WRITE);
                    o_cmd.set_voice   = (i_mode == pvm_pkg::MODE_SET);
                    o_cmd.start_voice = (i_mode == pvm_pkg::MODE_START);
                    o_cmd.stop_voice  = (i_mode == pvm_pkg::MODE_STOP);
                    o_cmd.tick_start  = (i_mode == pvm_pkg::MODE_TICK);
                end
            end
            pvm_pkg::S_VOICE: begin
                o_cmd.visit      = 1'b1;
                o_cmd.next_voice = !i_st.contrib && !i_st.last;
            end
            pvm_pkg::S_SCALE: o_cmd.scale = 1'b1;
            pvm_pkg::S_SAT:   o_cmd.sat = 1'b1;
            pvm_pkg::S_MUL_L: o_cmd.mul = 1'b1;
            pvm_pkg::S_ADD_L: begin
                o_cmd.add        = 1'b1;
                o_cmd.next_voice = !i_st.use_r && !i_st.last;
            end
            pvm_pkg::S_MUL_R: begin
                o_cmd.mul = 1'b1;
                o_cmd.ch  = 1'b1;
            end
            pvm_pkg::S_ADD_R: begin
                o_cmd.add        = 1'b1;
                o_cmd.ch         = 1'b1;
                o_cmd.next_voice = !i_st.last;
            end
            pvm_pkg::S_DONE:  o_cmd.out_load = !i_st.out_busy;
            default: o_cmd = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_tick_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == pvm_pkg::MODE_TICK) |=> r_state == pvm_pkg::S_VOICE)
        else $error("tick did not start the voice walk");
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvm_pkg::S_DONE && !i_st.out_busy) |=> r_state == pvm_pkg::S_IDLE)
        else $error("frame not released");
    a_left_then_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvm_pkg::S_ADD_L && i_st.use_r) |=> r_state == pvm_pkg::S_MUL_R)
        else $error("right channel skipped");
    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> !o_cmd.out_load)
        else $error("frame loaded twice");
`endif

endmodule

// ----- sv/pvm_datapath.sv -----
// voice registers, sample memory, scaler and mixer of the pcm voice mixer
module pvm_datapath #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pvm_pkg::t_cmd      i_cmd,
    input  logic [3:0]         i_voice,
    input  logic [15:0]        i_address,
    input  logic signed [15:0] i_sample_value,
    input  logic [15:0]        i_play_length,
    input  logic               i_loop_enable,
    input  logic [3:0]         i_extra_plays,
    input  logic               i_play_reverse,
    input  logic [15:0]        i_gain,
    input  logic signed [1:0]  i_pan,
    input  logic               i_out_stall,
    output pvm_pkg::t_status   o_st,
    output logic               o_out_valid,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);

    logic        r_active  [VOICES];
    logic [15:0] r_pos     [VOICES];
    logic [3:0]  r_plays   [VOICES];
    logic [15:0] r_start   [VOICES];
    logic [15:0] r_len     [VOICES];
    logic        r_loop    [VOICES];
    logic [3:0]  r_repeat  [VOICES];
    logic        r_rev     [VOICES];
    logic [15:0] r_gain_v  [VOICES];
    logic [1:0]  r_pan     [VOICES];

    logic [15:0] mem [SAMPLE_DEPTH];

    logic [VW-1:0]      r_cnt;
    logic [15:0]        r_rdata;
    logic [15:0]        r_gain;
    logic               r_use_l;
    logic               r_use_r;
    logic signed [32:0] r_prod;
    logic signed [15:0] r_scaled;
    logic [15:0]        r_a;
    logic [15:0]        r_b;
    logic [31:0]        r_ab;
    logic signed [15:0] r_acc_l;
    logic signed [15:0] r_acc_r;
    logic               r_out_valid;
    logic [15:0]        r_out_l;
    logic [15:0]        r_out_r;

    logic [6:0]    voice_ext;
    logic          voice_ok;
    logic [VW-1:0] vidx;
    logic [VW-1:0] ri;
    logic          wrap;
    logic [15:0]   pos_eff;
    logic          die;
    logic          dec;
    logic          contrib;
    logic [15:0]   rel;
    logic [15:0]   addr_full;
    logic [AW-1:0] rd_addr;

    logic signed [32:0] prod_adj;
    logic signed [17:0] quot;
    logic signed [15:0] sat16;
    logic [15:0]        a_op;
    logic [16:0]        m1;
    logic [17:0]        m2;
    logic [17:0]        m;
    logic [15:0]        mixed;

    assign voice_ext = {3'b000, i_voice};
    assign voice_ok  = voice_ext < 7'(VOICES);
    assign vidx      = voice_ext[VW-1:0];
    assign ri        = i_cmd.visit ? r_cnt : vidx;

    // per-voice bookkeeping for the visit
    always_comb begin
        wrap      = r_pos[ri] >= r_len[ri];
        pos_eff   = wrap ? 16'd0 : r_pos[ri];
        die       = wrap && !r_loop[ri] && (r_plays[ri] == 4'd0);
        dec       = wrap && !r_loop[ri] && (r_plays[ri] != 4'd0);
        contrib   = r_active[ri] && !die && (r_len[ri] != 16'd0);
        rel       = r_rev[ri] ? (r_len[ri] - 16'd1 - pos_eff) : pos_eff;
        addr_full = r_start[ri] + rel;
        rd_addr   = addr_full[AW-1:0];
    end

    assign o_st.contrib  = contrib;
    assign o_st.use_l    = r_use_l;
    assign o_st.use_r    = r_use_r;
    assign o_st.last     = (r_cnt == VW'(VOICES - 1));
    assign o_st.out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < VOICES; n++) begin
                r_active[n] <= 1'b0;
                r_pos[n]    <= '0;
                r_plays[n]  <= '0;
                r_start[n]  <= '0;
                r_len[n]    <= '0;
                r_loop[n]   <= 1'b0;
                r_repeat[n] <= '0;
                r_rev[n]    <= 1'b0;
                r_gain_v[n] <= pvm_pkg::UNITY_GAIN;
                r_pan[n]    <= '0;
            end
        end else begin
            if (i_cmd.set_voice && voice_ok) begin
                r_start[ri]  <= i_address;
                r_len[ri]    <= i_play_length;
                r_loop[ri]   <= i_loop_enable;
                r_repeat[ri] <= i_extra_plays;
                r_rev[ri]    <= i_play_reverse;
                r_gain_v[ri] <= i_gain;
                r_pan[ri]    <= i_pan;
            end
            if (i_cmd.start_voice && voice_ok) begin
                r_active[ri] <= 1'b1;
                r_pos[ri]    <= '0;
                r_plays[ri]  <= r_repeat[ri];
            end
            if (i_cmd.stop_voice && voice_ok) begin
                r_active[ri] <= 1'b0;
            end
            if (i_cmd.visit && r_active[ri]) begin
                if (die) begin
                    r_active[ri] <= 1'b0;
                end
                if (dec) begin
                    r_plays[ri] <= r_plays[ri] - 4'd1;
                end
                r_pos[ri] <= contrib ? pos_eff + 16'd1 : pos_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mem) begin
            mem[i_address[AW-1:0]] <= i_sample_value;
        end
        if (i_cmd.visit) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.tick_start) begin
            r_cnt <= '0;
        end else if (i_cmd.next_voice) begin
            r_cnt <= r_cnt + VW'(1);
        end
    end

    // scale by gain, truncating toward zero, then saturate
    always_comb begin
        prod_adj = r_prod + (r_prod[32] ? 33'sd32767 : 33'sd0);
        quot     = 18'(prod_adj >>> 15);
        if (quot > 18'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (quot < -18'sd32768) begin
            sat16 = -16'sh8000;
        end else begin
            sat16 = quot[15:0];
        end
    end

    // nonlinear mix of offset-binary operands
    always_comb begin
        a_op = i_cmd.ch ? r_acc_r : r_acc_l;
        m1   = r_ab[31:15];
        m2   = (({2'b00, r_a} + {2'b00, r_b}) << 1) - {1'b0, m1} - 18'd65536;
        m    = (r_a[15] && r_b[15]) ? m2 : {1'b0, m1};
        mixed = (m >= 18'd65536) ? 16'hffff : m[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.visit) begin
            r_gain  <= r_gain_v[ri];
            r_use_l <= !r_pan[ri][1];
            r_use_r <= r_pan[ri] != pvm_pkg::PAN_LEFT;
        end
        if (i_cmd.scale) begin
            r_prod <= $signed(r_rdata) * $signed({1'b0, r_gain});
        end
        if (i_cmd.sat) begin
            r_scaled <= sat16;
        end
        if (i_cmd.mul) begin
            r_a  <= a_op ^ 16'h8000;
            r_b  <= r_scaled ^ 16'h8000;
            r_ab <= {a_op[15] ^ 1'b1, a_op[14:0]} * {r_scaled[15] ^ 1'b1, r_scaled[14:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (i_cmd.add) begin
            if (i_cmd.ch) begin
                r_acc_r <= mixed ^ 16'h8000;
            end else begin
                r_acc_l <= mixed ^ 16'h8000;
            end
        end
        if (i_cmd.out_load) begin
            r_out_l <= r_acc_l;
            r_out_r <= r_acc_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_out_l;
    assign o_right_sample = r_out_r;

endmodule

// ----- sv/pcm_voice_mixer.sv -----
// top level of the pcm voice mixer
//  channel  | handshake                   | payload
//  input    | i_in_valid / o_in_stall     | i_mode .. i_pan
//  output   | o_out_valid / i_out_stall   | o_left_sample, o_right_sample
// memory writes, voice setup, start and stop complete while the controller stays idle
// a tick visits each voice in turn; a sounding voice is scaled, saturated and mixed into
// its left, then its right channel through the one mix multiplier that both channels share.
// reset is synchronous, active low; sample memory is not cleared
// a finished frame waits in the output register; a further tick holds in its
// last state until that frame transfers
module pcm_voice_mixer #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic [3:0]         i_voice,
    input  logic [15:0]        i_address,
    input  logic signed [15:0] i_sample_value,
    input  logic [15:0]        i_play_length,
    input  logic               i_loop_enable,
    input  logic [3:0]         i_extra_plays,
    input  logic               i_play_reverse,
    input  logic [15:0]        i_gain,
    input  logic signed [1:0]  i_pan,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample
);

    pvm_pkg::t_cmd    cmd;
    pvm_pkg::t_status st;

    pvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pvm_datapath #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_voice        (i_voice),
        .i_address      (i_address),
        .i_sample_value (i_sample_value),
        .i_play_length  (i_play_length),
        .i_loop_enable  (i_loop_enable),
        .i_extra_plays  (i_extra_plays),
        .i_play_reverse (i_play_reverse),
        .i_gain         (i_gain),
        .i_pan          (i_pan),
        .i_out_stall    (i_out_stall),
        .o_st           (st),
        .o_out_valid    (o_out_valid),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample)
    );

endmodule
